// File: rtl/lsc_pkg.sv
package lsc_pkg;

   localparam int COORD_FRAC_BITS = 14;
   localparam int COORD_W         = COORD_FRAC_BITS + 4;
   // Differences of two coordinates need one more bit.
   localparam int DIFF_W          = COORD_W + 1;
   localparam int MAG_W           = DIFF_W;
   // The line parameter t carries 32 fraction bits and saturates at 2.0.
   localparam int T_FRAC          = 32;
   localparam int QW              = T_FRAC + 2;
   localparam int TW              = QW + 1;
   localparam int DIV_STEP        = 2;
   localparam int DIV_STAGES      = QW / DIV_STEP;
   localparam int DIV_LAT         = DIV_STAGES + 2;
   localparam int PROD_W          = MAG_W + T_FRAC + 1;
   localparam int RND_W           = PROD_W - T_FRAC;
   localparam int NUM_BND         = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [TW-1:0]      tval_type;

   typedef enum logic [1:0] {
      REG_X_MIN = 2'd0,
      REG_X_MAX = 2'd1,
      REG_Y_MIN = 2'd2,
      REG_Y_MAX = 2'd3
   } csr_idx_type;

   localparam coord_type WIN_MIN_RST = COORD_W'(-(2 ** COORD_FRAC_BITS));
   localparam coord_type WIN_MAX_RST = COORD_W'(2 ** COORD_FRAC_BITS);

endpackage

// File: rtl/lsc_req_if.sv
interface lsc_req_if import lsc_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: rtl/lsc_rsp_if.sv
interface lsc_rsp_if import lsc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      visible;
   coord_type clip_start_x;
   coord_type clip_start_y;
   coord_type clip_end_x;
   coord_type clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, input ready);
   modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                 clip_end_y, output ready);
endinterface

// File: rtl/lsc_csr_if.sv
interface lsc_csr_if import lsc_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   coord_type   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lsc_divider.sv
module lsc_divider import lsc_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  diff_type p_in,
   input  diff_type q_in,
   output tval_type t_out
);

   logic [MAG_W-1:0] rem_ff [0:DIV_STAGES];
   logic [MAG_W-1:0] den_ff [0:DIV_STAGES];
   logic [QW-1:0]    num_ff [0:DIV_STAGES];
   logic [QW-1:0]    quo_ff [0:DIV_STAGES];
   logic             sat_ff [0:DIV_STAGES];
   logic             neg_ff [0:DIV_STAGES];
   tval_type         t_ff;

   logic [MAG_W-1:0] ap_in;
   logic [MAG_W-1:0] aq_in;
   logic             sat_in;
   logic [QW-1:0]    m_in;
   tval_type         t_in;

   always_comb begin
      ap_in  = p_in[DIFF_W-1] ? MAG_W'(-p_in) : MAG_W'(p_in);
      aq_in  = q_in[DIFF_W-1] ? MAG_W'(-q_in) : MAG_W'(q_in);
      sat_in = {1'b0, aq_in} >= {ap_in, 1'b0};
   end

   // The dividend is |q| * 2^32 + |p|/2, which rounds the quotient to nearest.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= aq_in >> 2;
         den_ff[0] <= ap_in;
         num_ff[0] <= {aq_in[1:0], T_FRAC'(ap_in >> 1)};
         quo_ff[0] <= '0;
         sat_ff[0] <= sat_in;
         neg_ff[0] <= p_in[DIFF_W-1] ^ q_in[DIFF_W-1];
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      logic [MAG_W-1:0] rem_in;
      logic [QW-1:0]    num_in;
      logic [QW-1:0]    quo_in;

      always_comb begin
         logic [MAG_W:0] trial;
         rem_in = rem_ff[k-1];
         num_in = num_ff[k-1];
         quo_in = quo_ff[k-1];
         for (int j = 0; j < DIV_STEP; j++) begin
            trial  = {rem_in, num_in[QW-1]};
            num_in = {num_in[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_ff[k-1]}) begin
               trial  = trial - {1'b0, den_ff[k-1]};
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
            rem_in = trial[MAG_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= num_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   always_comb begin
      m_in = sat_ff[DIV_STAGES] ? (QW'(1) << (QW - 1)) : quo_ff[DIV_STAGES];
      t_in = neg_ff[DIV_STAGES] ? -TW'(m_in) : TW'(m_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
      end
   end

   assign t_out = t_ff;

endmodule

// File: rtl/line_segment_window_clipper.sv
// Line segment clipper against a rectangular window (Liang-Barsky), Q4.14.
//
// req_ch carries one segment per word (start and end point). rsp_ch returns
// one word per segment: the visible flag and the clipped endpoints, or all
// zero coordinates when the segment misses the window. csr_ch writes the
// four window bounds; it is always ready and should only be written while
// no segment is in flight.
//
// The datapath is a 24-stage pipeline: one stage forms p and q, four
// dividers follow (two quotient bits per stage, 34 bits), two stages
// narrow t0 and t1, one multiplies and the last rounds into the output
// register. The accepting edge loads the first stage, and a new segment
// is accepted on every clock while the receiver does not stall.
//
// When the receiver stalls with a word waiting, the whole pipeline holds and
// req_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and loads the window with -1.0 .. +1.0.
module line_segment_window_clipper import lsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   lsc_req_if.sink   req_ch,
   lsc_rsp_if.source rsp_ch,
   lsc_csr_if.sink   csr_ch
);

   typedef struct packed {
      coord_type            sx;
      coord_type            sy;
      diff_type             dx;
      diff_type             dy;
      logic [NUM_BND-1:0]   pzero;
      logic [NUM_BND-1:0]   pneg;
      logic [NUM_BND-1:0]   qneg;
   } side_type;

   typedef struct packed {
      logic     ok;
      tval_type t0;
      tval_type t1;
   } bnd_type;

   function automatic bnd_type narrow(input bnd_type st, input logic pzero,
                                      input logic pneg, input logic qneg,
                                      input tval_type t);
      bnd_type r;
      r = st;
      if (pzero) begin
         if (qneg) r.ok = 1'b0;
      end else if (pneg) begin
         if (t > st.t1) r.ok = 1'b0;
         else if (t > st.t0) r.t0 = t;
      end else begin
         if (t < st.t0) r.ok = 1'b0;
         else if (t < st.t1) r.t1 = t;
      end
      return r;
   endfunction

   function automatic coord_type lerp(input coord_type s, input logic dneg,
                                      input logic [PROD_W-1:0] prod);
      logic [PROD_W-1:0]       sum;
      logic [RND_W-1:0]        r;
      logic signed [RND_W-1:0] rs;
      logic signed [RND_W-1:0] total;
      sum   = prod + (PROD_W'(1) << (T_FRAC - 1));
      r     = sum[T_FRAC +: RND_W];
      rs    = dneg ? -$signed(r) : $signed(r);
      total = RND_W'(s) + rs;
      return total[COORD_W-1:0];
   endfunction

   localparam bnd_type BND_INIT = '{ok: 1'b1, t0: '0, t1: TW'(64'd1 << T_FRAC)};

   coord_type win_x_min_ff, win_x_max_ff, win_y_min_ff, win_y_max_ff;

   logic     en;
   logic     vld_ff  [0:DIV_LAT];
   side_type side_ff [0:DIV_LAT];
   diff_type q_ff    [NUM_BND];
   diff_type p_s0    [NUM_BND];
   tval_type t_div   [NUM_BND];

   side_type side_in;
   diff_type q_in    [NUM_BND];

   logic     d1_vld_ff, d2_vld_ff, m_vld_ff, rsp_valid_ff;
   side_type d1_side_ff, d2_side_ff;
   bnd_type  d1_st_ff, d2_st_ff;
   tval_type d1_t2_ff, d1_t3_ff;
   bnd_type  d1_st_in, d2_st_in;

   logic              m_ok_ff, m_dxneg_ff, m_dyneg_ff;
   coord_type         m_sx_ff, m_sy_ff;
   logic [PROD_W-1:0] m_prod_ff [NUM_BND];
   logic [MAG_W-1:0]  adx_in, ady_in;

   logic      vis_ff;
   coord_type csx_ff, csy_ff, cex_ff, cey_ff;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_min_ff <= WIN_MIN_RST;
         win_x_max_ff <= WIN_MAX_RST;
         win_y_min_ff <= WIN_MIN_RST;
         win_y_max_ff <= WIN_MAX_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_X_MIN: win_x_min_ff <= csr_ch.data;
            REG_X_MAX: win_x_max_ff <= csr_ch.data;
            REG_Y_MIN: win_y_min_ff <= csr_ch.data;
            REG_Y_MAX: win_y_max_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Boundary order: left, right, bottom, top; p is -dx, dx, -dy, dy.
   always_comb begin
      side_in.sx = req_ch.start_x;
      side_in.sy = req_ch.start_y;
      side_in.dx = DIFF_W'(req_ch.end_x) - DIFF_W'(req_ch.start_x);
      side_in.dy = DIFF_W'(req_ch.end_y) - DIFF_W'(req_ch.start_y);
      q_in[0] = DIFF_W'(req_ch.start_x) - DIFF_W'(win_x_min_ff);
      q_in[1] = DIFF_W'(win_x_max_ff) - DIFF_W'(req_ch.start_x);
      q_in[2] = DIFF_W'(req_ch.start_y) - DIFF_W'(win_y_min_ff);
      q_in[3] = DIFF_W'(win_y_max_ff) - DIFF_W'(req_ch.start_y);
      side_in.pzero = {side_in.dy == '0, side_in.dy == '0,
                       side_in.dx == '0, side_in.dx == '0};
      side_in.pneg  = {side_in.dy[DIFF_W-1], side_in.dy > 0,
                       side_in.dx[DIFF_W-1], side_in.dx > 0};
      side_in.qneg  = {q_in[3][DIFF_W-1], q_in[2][DIFF_W-1],
                       q_in[1][DIFF_W-1], q_in[0][DIFF_W-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 0; i < NUM_BND; i++) begin
            q_ff[i] <= q_in[i];
         end
      end
   end

   for (genvar k = 1; k <= DIV_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign p_s0[0] = -side_ff[0].dx;
   assign p_s0[1] = side_ff[0].dx;
   assign p_s0[2] = -side_ff[0].dy;
   assign p_s0[3] = side_ff[0].dy;

   for (genvar i = 0; i < NUM_BND; i++) begin : g_div
      lsc_divider u_div (
         .clock (clock),
         .en    (en),
         .p_in  (p_s0[i]),
         .q_in  (q_ff[i]),
         .t_out (t_div[i])
      );
   end

   always_comb begin
      bnd_type st;
      st = BND_INIT;
      st = narrow(st, side_ff[DIV_LAT].pzero[0], side_ff[DIV_LAT].pneg[0],
                  side_ff[DIV_LAT].qneg[0], t_div[0]);
      st = narrow(st, side_ff[DIV_LAT].pzero[1], side_ff[DIV_LAT].pneg[1],
                  side_ff[DIV_LAT].qneg[1], t_div[1]);
      d1_st_in = st;
   end

   always_comb begin
      bnd_type st;
      st = narrow(d1_st_ff, d1_side_ff.pzero[2], d1_side_ff.pneg[2],
                  d1_side_ff.qneg[2], d1_t2_ff);
      st = narrow(st, d1_side_ff.pzero[3], d1_side_ff.pneg[3],
                  d1_side_ff.qneg[3], d1_t3_ff);
      if (st.t0 > st.t1) st.ok = 1'b0;
      d2_st_in = st;
   end

   assign adx_in = d2_side_ff.dx[DIFF_W-1] ? MAG_W'(-d2_side_ff.dx) : MAG_W'(d2_side_ff.dx);
   assign ady_in = d2_side_ff.dy[DIFF_W-1] ? MAG_W'(-d2_side_ff.dy) : MAG_W'(d2_side_ff.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff    <= 1'b0;
         d2_vld_ff    <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         d1_vld_ff    <= vld_ff[DIV_LAT];
         d2_vld_ff    <= d1_vld_ff;
         m_vld_ff     <= d2_vld_ff;
         rsp_valid_ff <= m_vld_ff;
      end
   end

   // Once visible, 0 <= t0 <= t1 <= 1, so the low 33 bits of t are its value.
   always_ff @(posedge clock) begin
      if (en) begin
         d1_side_ff   <= side_ff[DIV_LAT];
         d1_st_ff     <= d1_st_in;
         d1_t2_ff     <= t_div[2];
         d1_t3_ff     <= t_div[3];
         d2_side_ff   <= d1_side_ff;
         d2_st_ff     <= d2_st_in;
         m_ok_ff      <= d2_st_ff.ok;
         m_sx_ff      <= d2_side_ff.sx;
         m_sy_ff      <= d2_side_ff.sy;
         m_dxneg_ff   <= d2_side_ff.dx[DIFF_W-1];
         m_dyneg_ff   <= d2_side_ff.dy[DIFF_W-1];
         m_prod_ff[0] <= PROD_W'(adx_in) * PROD_W'(d2_st_ff.t0[T_FRAC:0]);
         m_prod_ff[1] <= PROD_W'(ady_in) * PROD_W'(d2_st_ff.t0[T_FRAC:0]);
         m_prod_ff[2] <= PROD_W'(adx_in) * PROD_W'(d2_st_ff.t1[T_FRAC:0]);
         m_prod_ff[3] <= PROD_W'(ady_in) * PROD_W'(d2_st_ff.t1[T_FRAC:0]);
         vis_ff       <= m_ok_ff;
         csx_ff       <= m_ok_ff ? lerp(m_sx_ff, m_dxneg_ff, m_prod_ff[0]) : '0;
         csy_ff       <= m_ok_ff ? lerp(m_sy_ff, m_dyneg_ff, m_prod_ff[1]) : '0;
         cex_ff       <= m_ok_ff ? lerp(m_sx_ff, m_dxneg_ff, m_prod_ff[2]) : '0;
         cey_ff       <= m_ok_ff ? lerp(m_sy_ff, m_dyneg_ff, m_prod_ff[3]) : '0;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.visible      = vis_ff;
   assign rsp_ch.clip_start_x = csx_ff;
   assign rsp_ch.clip_start_y = csy_ff;
   assign rsp_ch.clip_end_x   = cex_ff;
   assign rsp_ch.clip_end_y   = cey_ff;

`ifndef SYNTH
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.visible |->
         rsp_ch.clip_start_x == '0 && rsp_ch.clip_start_y == '0 &&
         rsp_ch.clip_end_x == '0 && rsp_ch.clip_end_y == '0)
      else $error("rejected segment carries nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid && csr_ch.index == REG_X_MIN |=> win_x_min_ff == $past(csr_ch.data))
      else $error("left bound write not taken");
`endif

endmodule

// File: tb/tb_pkg_unused.sv
package clip_tb_pkg;
   import lsc_pkg::*;

   typedef struct {
      coord_type sx, sy, ex, ey;
   } segment_type;

   typedef struct {
      logic      vis;
      coord_type csx, csy, cex, cey;
   } clipped_type;
endpackage

// File: tb/testbench.sv
module testbench;
   import lsc_pkg::*;
   import clip_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsc_req_if req_ch();
   lsc_rsp_if rsp_ch();
   lsc_csr_if csr_ch();

   line_segment_window_clipper u_top (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam longint T_ONE = 64'sd1 <<< 32;

   // Window bounds as the predictor sees them.
   longint wx_min, wx_max, wy_min, wy_max;

   segment_type pending_segs[$];
   clipped_type expected_clips[$];

   int send_idle_pct, recv_stall_pct;
   int hold_off_cycles;
   int mismatches;
   longint cycle_count;

   // csr write request, handed from the initial block to the driver.
   bit          csr_pending;
   csr_idx_type csr_idx;
   coord_type   csr_val;

   function automatic longint divide_t(longint q, longint p);
      longint aq, ap, m;
      aq = (q < 0) ? -q : q;
      ap = (p < 0) ? -p : p;
      if (aq >= 2 * ap) m = 2 * T_ONE;
      else m = ((aq <<< 32) + (ap >>> 1)) / ap;
      return ((q < 0) != (p < 0)) ? -m : m;
   endfunction

   function automatic coord_type interp(longint s, longint d, longint t);
      logic [63:0] prod;
      longint r;
      prod = 64'(((d < 0) ? -d : d)) * 64'(t);
      r = longint'((prod + (64'd1 << 31)) >> 32);
      if (d < 0) r = -r;
      return coord_type'(s + r);
   endfunction

   function automatic clipped_type clip_segment(segment_type g);
      longint sx, sy, dx, dy, t0, t1, t;
      longint p[4], q[4];
      bit ok;
      clipped_type c;
      sx = longint'(g.sx); sy = longint'(g.sy);
      dx = longint'(g.ex) - sx;
      dy = longint'(g.ey) - sy;
      t0 = 0; t1 = T_ONE; ok = 1'b1;
      p[0] = -dx; q[0] = sx - wx_min;
      p[1] = dx;  q[1] = wx_max - sx;
      p[2] = -dy; q[2] = sy - wy_min;
      p[3] = dy;  q[3] = wy_max - sy;
      for (int i = 0; i < 4; i++) begin
         if (ok) begin
            if (p[i] == 0) begin
               if (q[i] < 0) ok = 1'b0;
            end else begin
               t = divide_t(q[i], p[i]);
               if (p[i] < 0) begin
                  if (t > t1) ok = 1'b0;
                  else if (t > t0) t0 = t;
               end else begin
                  if (t < t0) ok = 1'b0;
                  else if (t < t1) t1 = t;
               end
            end
         end
      end
      if (ok && t0 > t1) ok = 1'b0;
      c = '{1'b0, '0, '0, '0, '0};
      if (ok) begin
         c.vis = 1'b1;
         c.csx = interp(sx, dx, t0);
         c.csy = interp(sy, dy, t0);
         c.cex = interp(sx, dx, t1);
         c.cey = interp(sy, dy, t1);
      end
      return c;
   endfunction

   // Driver: the segment word and csr writes.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_X_MIN: wx_min = longint'(csr_ch.data);
               REG_X_MAX: wx_max = longint'(csr_ch.data);
               REG_Y_MIN: wy_min = longint'(csr_ch.data);
               default:   wy_max = longint'(csr_ch.data);
            endcase
            csr_pending = 1'b0;
         end
         csr_ch.valid <= csr_pending;
         csr_ch.index <= csr_idx;
         csr_ch.data  <= csr_val;
         if (req_ch.valid && req_ch.ready) begin
            expected_clips.push_back(clip_segment(pending_segs.pop_front()));
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.start_x <= pending_segs[0].sx;
               req_ch.start_y <= pending_segs[0].sy;
               req_ch.end_x   <= pending_segs[0].ex;
               req_ch.end_y   <= pending_segs[0].ey;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result word with the oldest expectation.
   always @(posedge clock) begin
      clipped_type e;
      cycle_count++;
      if (cycle_count > 64'd2000000) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_clips.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word");
            end else begin
               e = expected_clips.pop_front();
               if (e.vis !== rsp_ch.visible || e.csx !== rsp_ch.clip_start_x ||
                   e.csy !== rsp_ch.clip_start_y || e.cex !== rsp_ch.clip_end_x ||
                   e.cey !== rsp_ch.clip_end_y) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %b %0d %0d %0d %0d got %b %0d %0d %0d %0d",
                              e.vis, e.csx, e.csy, e.cex, e.cey, rsp_ch.visible,
                              rsp_ch.clip_start_x, rsp_ch.clip_start_y,
                              rsp_ch.clip_end_x, rsp_ch.clip_end_y);
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic wait_drained();
      while (pending_segs.size() > 0 || expected_clips.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_bound(csr_idx_type idx, coord_type v);
      csr_idx = idx;
      csr_val = v;
      csr_pending = 1'b1;
      while (csr_pending) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_window(longint x0, longint x1, longint y0, longint y1);
      wait_drained();
      write_bound(REG_X_MIN, coord_type'(x0));
      write_bound(REG_X_MAX, coord_type'(x1));
      write_bound(REG_Y_MIN, coord_type'(y0));
      write_bound(REG_Y_MAX, coord_type'(y1));
   endtask

   task automatic add_seg(longint a, longint b, longint c, longint d);
      segment_type g;
      g = '{coord_type'(a), coord_type'(b), coord_type'(c), coord_type'(d)};
      pending_segs.push_back(g);
   endtask

   // Mostly coordinates near the window, sometimes anywhere, sometimes a bound.
   function automatic coord_type near_coord(longint lo, longint hi);
      int k;
      k = $urandom_range(9);
      if (k < 2) return coord_type'($urandom);
      if (k == 2) return coord_type'(($urandom_range(1) == 0) ? lo : hi);
      return coord_type'(lo - (hi - lo) / 2 +
                         longint'($urandom_range(0, 32'(2 * (hi - lo) + 1))));
   endfunction

   task automatic random_segments(int n, longint lo, longint hi);
      segment_type g;
      for (int i = 0; i < n; i++) begin
         g.sx = near_coord(lo, hi); g.sy = near_coord(lo, hi);
         if ($urandom_range(15) == 0) begin
            g.ex = g.sx; g.ey = g.sy;
         end else if ($urandom_range(7) == 0) begin
            g.ex = g.sx; g.ey = near_coord(lo, hi);
         end else begin
            g.ex = near_coord(lo, hi); g.ey = near_coord(lo, hi);
         end
         pending_segs.push_back(g);
      end
   endtask

   task automatic run_phase(int idle, int stall, int n, longint lo, longint hi);
      wait_drained();
      send_idle_pct = idle;
      recv_stall_pct = stall;
      random_segments(n, lo, hi);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.start_x = '0; req_ch.start_y = '0;
      req_ch.end_x = '0;   req_ch.end_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = REG_X_MIN; csr_ch.data = '0;
      csr_pending = 1'b0; csr_idx = REG_X_MIN; csr_val = '0;
      wx_min = -16384; wx_max = 16384; wy_min = -16384; wy_max = 16384;
      send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
      mismatches = 0; cycle_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset window, crossing, inside, outside, parallel, degenerate.
      add_seg(-32768, 0, 32768, 0);
      add_seg(-8192, -8192, 8192, 8192);
      add_seg(-131072, -131072, 131071, 131071);
      add_seg(131071, 131071, -131072, -131072);
      add_seg(-131072, 131071, 131071, -131072);
      add_seg(0, 20000, 100, 30000);
      add_seg(20000, 0, 20000, 5000);
      add_seg(-20000, -20000, -20000, 20000);
      add_seg(1000, 2000, 1000, 2000);
      add_seg(30000, 30000, 30000, 30000);
      add_seg(16384, 16384, 16384, 16384);
      add_seg(-16384, 0, 16384, 1);
      add_seg(0, -40000, 1, 40000);
      add_seg(20000, 20000, 40000, -40000);
      add_seg(-17000, 0, 0, 17000);
      add_seg(3, -5, -7, 11);
      add_seg(0, 0, 65535, 65536);
      // Inverted window rejects everything; then the full-range extremes.
      set_window(16384, -16384, 0, 100);
      add_seg(0, 0, 1, 1);
      add_seg(-131072, 50, 131071, 50);
      set_window(-131072, 131071, -131072, 131071);
      add_seg(-131072, -131072, 131071, 131071);
      add_seg(131071, -131072, -131072, 131071);
      add_seg(5, 5, 5, 5);
      set_window(0, 0, 0, 0);
      add_seg(-1, -1, 1, 1);
      add_seg(0, 0, 0, 0);

      set_window(-16384, 16384, -16384, 16384);
      run_phase(0, 0, 200, -16384, 16384);
      // Receiver holds off for a long stretch while the sender keeps going.
      wait_drained();
      hold_off_cycles = 200;
      random_segments(100, -16384, 16384);
      run_phase(54, 0, 200, -16384, 16384);
      set_window(-40000, 10000, -3000, 60000);
      run_phase(0, 54, 200, -40000, 60000);
      set_window(-131072, 131071, -100, 100);
      run_phase(18, 18, 150, -131072, 131071);
      set_window(100, 200, -131072, 131071);
      run_phase(54, 54, 100, -1000, 1000);
      set_window(-5000, 5000, -5000, 5000);
      run_phase(0, 0, 250, -5000, 5000);
      wait_drained();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
